// ===== rtl/lfk_pkg.sv =====
// ----------------------------------------------------------------------------
// lfk_pkg
// Shared constants, types and helpers for the leg forward kinematics block.
// ----------------------------------------------------------------------------
package lfk_pkg;

  localparam int unsigned TRIG_ITERATIONS = 16;
  localparam int unsigned MAX_ITERATIONS  = 24;

  localparam int unsigned LEN_W   = 14;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned FOOT_W  = 17;
  localparam int unsigned TRIG_W  = 18;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COXA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEMUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIBIA = 2'd2;

  localparam logic [LEN_W-1:0] COXA_RESET  = 14'd800;
  localparam logic [LEN_W-1:0] FEMUR_RESET = 14'd1200;
  localparam logic [LEN_W-1:0] TIBIA_RESET = 14'd1600;

  // angle reduction front end + final rounding stage
  localparam int unsigned SINCOS_FIXED_LAT = 5;
  localparam int unsigned KIN_LAT          = 6;

  localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sd652032874;

  localparam logic signed [32:0] ATAN_Q30 [MAX_ITERATIONS] = '{
    33'sd843314857, 33'sd497837830, 33'sd263043837, 33'sd133525159,
    33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388438,
    33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
    33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
    33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
    33'sd1024,      33'sd512,       33'sd256,       33'sd128
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin;
    logic signed [TRIG_W-1:0] cos;
  } trig_t;

  function automatic logic signed [FOOT_W-1:0] sat_foot(input logic signed [55:0] v);
    logic signed [FOOT_W-1:0] r;
    if (v > 56'sd49152) begin
      r = 17'sd49152;
    end else if (v < -56'sd49152) begin
      r = -17'sd49152;
    end else begin
      r = v[FOOT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/lfk_in_if.sv =====
// ----------------------------------------------------------------------------
// lfk_in_if
// Joint angle channel: valid/ready with three angles in 0.01 degree.
// ----------------------------------------------------------------------------
interface lfk_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lfk_pkg::ANGLE_W-1:0]  coxa_angle;
  logic signed [lfk_pkg::ANGLE_W-1:0]  femur_angle;
  logic signed [lfk_pkg::ANGLE_W-1:0]  tibia_angle;

  modport source (output valid, output coxa_angle, output femur_angle,
                  output tibia_angle, input ready);
  modport sink   (input valid, input coxa_angle, input femur_angle,
                  input tibia_angle, output ready);
endinterface

// ===== rtl/lfk_out_if.sv =====
// ----------------------------------------------------------------------------
// lfk_out_if
// Foot position channel: valid/ready with x, y, z in 1/16 mm.
// ----------------------------------------------------------------------------
interface lfk_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lfk_pkg::FOOT_W-1:0]  foot_x;
  logic signed [lfk_pkg::FOOT_W-1:0]  foot_y;
  logic signed [lfk_pkg::FOOT_W-1:0]  foot_z;

  modport source (output valid, output foot_x, output foot_y, output foot_z,
                  input ready);
  modport sink   (input valid, input foot_x, input foot_y, input foot_z,
                  output ready);
endinterface

// ===== rtl/lfk_sincos.sv =====
// ----------------------------------------------------------------------------
// lfk_sincos
// Pipelined sine/cosine: angle wrap and fold, conversion to radians Q30,
// one CORDIC rotation per stage, rounding to Q16.
// ----------------------------------------------------------------------------
module lfk_sincos #(
  parameter int unsigned Iters = lfk_pkg::TRIG_ITERATIONS
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [16:0]    angle_i,
  output lfk_pkg::trig_t        trig_o
);

  logic signed [16:0] wrap;
  logic signed [16:0] fold;
  logic               fold_neg;
  logic signed [14:0] m_q;
  logic               neg1_q, neg2_q, neg3_q;

  always_comb begin
    wrap = angle_i;
    if (angle_i > 17'sd18000) begin
      wrap = angle_i - 17'sd36000;
    end else if (angle_i <= -17'sd18000) begin
      wrap = angle_i + 17'sd36000;
    end
    fold     = wrap;
    fold_neg = 1'b0;
    if (wrap > 17'sd9000) begin
      fold     = wrap - 17'sd18000;
      fold_neg = 1'b1;
    end else if (wrap < -17'sd9000) begin
      fold     = wrap + 17'sd18000;
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= fold[14:0];
      neg1_q <= fold_neg;
    end
  end

  // m*pi*2^30/18000 = m*187403 + (m*5426)/18000, remainder part offset positive
  logic signed [32:0] a_d, a_q, a3_q;
  logic signed [27:0] t_s;
  logic [26:0]        t_q, t3_q;

  assign a_d = 33'(m_q) * 33'sd187403;
  assign t_s = 28'(m_q) * 28'sd5426 + 28'sd48861000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      t_q    <= t_s[26:0];
      neg2_q <= neg1_q;
    end
  end

  logic [52:0] qe_prod;
  logic [12:0] qe_q;

  assign qe_prod = 53'(t_q) * 53'd61083979;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe_q   <= qe_prod[52:40];
      t3_q   <= t_q;
      a3_q   <= a_q;
      neg3_q <= neg2_q;
    end
  end

  logic [27:0]        rem;
  logic [12:0]        q_fix;
  logic signed [32:0] phi0_d;

  assign rem    = 28'(t3_q) - 28'(qe_q) * 28'd18000;
  assign q_fix  = qe_q + 13'((rem >= 28'd18000) ? 1 : 0);
  assign phi0_d = a3_q + $signed({20'd0, q_fix}) - 33'sd2714;

  logic signed [32:0] phi_q [Iters];
  logic signed [32:0] x_q   [Iters];
  logic signed [32:0] y_q   [Iters];
  logic               negc_q [Iters+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q[0]  <= phi0_d;
      negc_q[0] <= neg3_q;
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_rot
    logic signed [32:0] x_in, y_in;
    if (i == 0) begin : g_first
      assign x_in = lfk_pkg::CORDIC_INV_GAIN;
      assign y_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        negc_q[i+1] <= negc_q[i];
        if (!phi_q[i][32]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
        end
      end
    end

    if (i < Iters - 1) begin : g_phi
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!phi_q[i][32]) begin
            phi_q[i+1] <= phi_q[i] - lfk_pkg::ATAN_Q30[i];
          end else begin
            phi_q[i+1] <= phi_q[i] + lfk_pkg::ATAN_Q30[i];
          end
        end
      end
    end
  end

  logic signed [32:0] xr, yr;
  logic signed [lfk_pkg::TRIG_W-1:0] cs, sn;

  assign xr = (x_q[Iters-1] + 33'sd8192) >>> 14;
  assign yr = (y_q[Iters-1] + 33'sd8192) >>> 14;
  assign cs = xr[lfk_pkg::TRIG_W-1:0];
  assign sn = yr[lfk_pkg::TRIG_W-1:0];

  lfk_pkg::trig_t trig_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.cos <= negc_q[Iters] ? -cs : cs;
      trig_q.sin <= negc_q[Iters] ? -sn : sn;
    end
  end

  assign trig_o = trig_q;

endmodule

// ===== rtl/lfk_kinematics.sv =====
// ----------------------------------------------------------------------------
// lfk_kinematics
// Six-stage multiply/add pipeline from joint sines and cosines to the
// saturated foot position.
// ----------------------------------------------------------------------------
module lfk_kinematics (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [lfk_pkg::LEN_W-1:0]           coxa_len_i,
  input  logic [lfk_pkg::LEN_W-1:0]           femur_len_i,
  input  logic [lfk_pkg::LEN_W-1:0]           tibia_len_i,
  input  lfk_pkg::trig_t                      coxa_i,
  input  lfk_pkg::trig_t                      femur_i,
  input  lfk_pkg::trig_t                      tibia_i,
  output logic signed [lfk_pkg::FOOT_W-1:0]   foot_x_o,
  output logic signed [lfk_pkg::FOOT_W-1:0]   foot_y_o,
  output logic signed [lfk_pkg::FOOT_W-1:0]   foot_z_o
);

  logic signed [14:0] femur_s, tibia_s;
  assign femur_s = $signed({1'b0, femur_len_i});
  assign tibia_s = $signed({1'b0, tibia_len_i});

  // stage 1
  logic signed [35:0] p_ss_q, p_cc_q, p_sc_q, p_cs_q;
  logic signed [32:0] fs1_q, fc1_q;
  lfk_pkg::trig_t     a1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ss_q <= 36'(tibia_i.sin) * 36'(femur_i.sin);
      p_cc_q <= 36'(tibia_i.cos) * 36'(femur_i.cos);
      p_sc_q <= 36'(femur_i.sin) * 36'(tibia_i.cos);
      p_cs_q <= 36'(femur_i.cos) * 36'(tibia_i.sin);
      fs1_q  <= 33'(femur_s) * 33'(femur_i.sin);
      fc1_q  <= 33'(femur_s) * 33'(femur_i.cos);
      a1_q   <= coxa_i;
    end
  end

  // stage 2
  logic signed [36:0] sr_q, sz_q;
  logic signed [32:0] fs2_q, fc2_q;
  lfk_pkg::trig_t     a2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q  <= 37'(p_ss_q) + 37'(p_cc_q);
      sz_q  <= 37'(p_sc_q) - 37'(p_cs_q);
      fs2_q <= fs1_q;
      fc2_q <= fc1_q;
      a2_q  <= a1_q;
    end
  end

  // stage 3
  logic signed [51:0] tr_q, tz_q;
  logic signed [32:0] fs3_q, fc3_q;
  lfk_pkg::trig_t     a3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tr_q  <= 52'(tibia_s) * 52'(sr_q);
      tz_q  <= 52'(tibia_s) * 52'(sz_q);
      fs3_q <= fs2_q;
      fc3_q <= fc2_q;
      a3_q  <= a2_q;
    end
  end

  // stage 4: sums, rounding of reach and z
  logic signed [53:0] reach32, reach_r, z32, z_r;
  logic signed [37:0] reach_q;
  logic signed [lfk_pkg::FOOT_W-1:0] z4_q, z5_q;
  lfk_pkg::trig_t     a4_q;

  assign reach32 = 54'($signed({1'b0, coxa_len_i, 32'd0})) + (54'(fs3_q) <<< 16)
                 + 54'(tr_q);
  assign reach_r = (reach32 + 54'sd32768) >>> 16;
  assign z32     = 54'(tz_q) - (54'(fc3_q) <<< 16);
  assign z_r     = (z32 + 54'sd2147483648) >>> 32;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      reach_q <= reach_r[37:0];
      z4_q    <= lfk_pkg::sat_foot(56'(z_r));
      a4_q    <= a3_q;
    end
  end

  // stage 5
  logic signed [55:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= 56'(reach_q) * 56'(a4_q.cos);
      py_q <= 56'(reach_q) * 56'(a4_q.sin);
      z5_q <= z4_q;
    end
  end

  // stage 6: output register
  logic signed [55:0] px_r, py_r;
  assign px_r = (px_q + 56'sd2147483648) >>> 32;
  assign py_r = (py_q + 56'sd2147483648) >>> 32;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      foot_x_o <= lfk_pkg::sat_foot(px_r);
      foot_y_o <= lfk_pkg::sat_foot(py_r);
      foot_z_o <= z5_q;
    end
  end

endmodule

// ===== rtl/leg_forward_kinematics.sv =====
// ----------------------------------------------------------------------------
// leg_forward_kinematics
// Foot position of a three-segment leg from its coxa, femur and tibia angles.
// ----------------------------------------------------------------------------
// Takes one angle triple per clock and returns one foot position per
// transaction, in order, after angle reduction and rounding around one
// CORDIC stage per iteration, then six multiply/add stages. Throughput is
// one transaction per cycle; when the output is held off, the whole pipeline
// freezes and input ready drops with it. The user must write segment lengths
// through the configuration port only while the pipeline is empty; the block
// itself does not enforce this.
module leg_forward_kinematics #(
  parameter int unsigned TRIG_ITERATIONS = lfk_pkg::TRIG_ITERATIONS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lfk_in_if.sink                            in_i,
  lfk_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [lfk_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lfk_pkg::LEN_W-1:0]         cfg_data_i
);

  localparam int unsigned Lat = TRIG_ITERATIONS + lfk_pkg::SINCOS_FIXED_LAT
                              + lfk_pkg::KIN_LAT;

  logic [lfk_pkg::LEN_W-1:0] coxa_len_q, femur_len_q, tibia_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coxa_len_q  <= lfk_pkg::COXA_RESET;
      femur_len_q <= lfk_pkg::FEMUR_RESET;
      tibia_len_q <= lfk_pkg::TIBIA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfk_pkg::CFG_COXA:  coxa_len_q  <= cfg_data_i;
        lfk_pkg::CFG_FEMUR: femur_len_q <= cfg_data_i;
        lfk_pkg::CFG_TIBIA: tibia_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           en, in_acc;
  logic [Lat-1:0] vld_q;

  assign en         = !vld_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;
  assign in_acc     = in_i.valid && en;
  assign out_o.valid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_acc};
    end
  end

  lfk_pkg::trig_t coxa_trig, femur_trig, tibia_trig;
  logic signed [16:0] coxa_rel;

  assign coxa_rel = 17'(in_i.coxa_angle) - 17'sd9000;

  lfk_sincos #(.Iters(TRIG_ITERATIONS)) u_sincos_coxa (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (coxa_rel),
    .trig_o  (coxa_trig)
  );

  lfk_sincos #(.Iters(TRIG_ITERATIONS)) u_sincos_femur (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (17'(in_i.femur_angle)),
    .trig_o  (femur_trig)
  );

  lfk_sincos #(.Iters(TRIG_ITERATIONS)) u_sincos_tibia (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (17'(in_i.tibia_angle)),
    .trig_o  (tibia_trig)
  );

  lfk_kinematics u_kin (
    .clk_i       (clk_i),
    .en_i        (en),
    .coxa_len_i  (coxa_len_q),
    .femur_len_i (femur_len_q),
    .tibia_len_i (tibia_len_q),
    .coxa_i      (coxa_trig),
    .femur_i     (femur_trig),
    .tibia_i     (tibia_trig),
    .foot_x_o    (out_o.foot_x),
    .foot_y_o    (out_o.foot_y),
    .foot_z_o    (out_o.foot_z)
  );

  ap_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  ap_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted transaction not in first stage");

  ap_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.foot_x <= 17'sd49152 && out_o.foot_x >= -17'sd49152
                  && out_o.foot_y <= 17'sd49152 && out_o.foot_y >= -17'sd49152
                  && out_o.foot_z <= 17'sd49152 && out_o.foot_z >= -17'sd49152))
    else $error("foot position outside saturation range");

endmodule

// ===== bench/leg_forward_kinematics_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_forward_kinematics_tb
// Drives joint angle triples through the leg kinematics block under several
// segment length settings and handshake pressure levels, and compares every
// foot position against a bit-exact CORDIC based prediction.
// ----------------------------------------------------------------------------
module leg_forward_kinematics_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam longint FOOT_LIMIT = 49152;

  typedef struct {
    logic signed [lfk_pkg::FOOT_W-1:0] x;
    logic signed [lfk_pkg::FOOT_W-1:0] y;
    logic signed [lfk_pkg::FOOT_W-1:0] z;
  } foot_pos_t;

  class foot_scoreboard;
    foot_pos_t foot_q[$];
    longint coxa_len, femur_len, tibia_len;
    int errors;

    function new();
      coxa_len  = lfk_pkg::COXA_RESET;
      femur_len = lfk_pkg::FEMUR_RESET;
      tibia_len = lfk_pkg::TIBIA_RESET;
      errors    = 0;
    endfunction

    function void set_length(logic [lfk_pkg::CFG_IDX_W-1:0] idx,
                             logic [lfk_pkg::LEN_W-1:0] val);
      case (idx)
        lfk_pkg::CFG_COXA:  coxa_len  = val;
        lfk_pkg::CFG_FEMUR: femur_len = val;
        lfk_pkg::CFG_TIBIA: tibia_len = val;
        default: ;
      endcase
    endfunction

    function void sincos(longint hund, output longint sn, output longint cs);
      longint m, num, q, r, phi, x, y, nx, ny;
      bit neg;
      neg = 0;
      m = hund % 36000;
      if (m < 0) m += 36000;
      if (m > 18000) m -= 36000;
      if (m > 9000) begin
        m -= 18000;
        neg = 1;
      end else if (m < -9000) begin
        m += 18000;
        neg = 1;
      end
      num = m * PI_Q30_L;
      q = num / 18000;
      r = num % 18000;
      if (r < 0) begin
        q -= 1;
        r += 18000;
      end
      if (2 * r >= 18000) q += 1;
      phi = q;
      x = lfk_pkg::CORDIC_INV_GAIN;
      y = 0;
      for (int i = 0; i < lfk_pkg::TRIG_ITERATIONS && i < lfk_pkg::MAX_ITERATIONS; i++) begin
        if (phi >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          phi -= longint'(lfk_pkg::ATAN_Q30[i]);
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          phi += longint'(lfk_pkg::ATAN_Q30[i]);
        end
        x = nx;
        y = ny;
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      cs = neg ? -x : x;
      sn = neg ? -y : y;
    endfunction

    function logic signed [lfk_pkg::FOOT_W-1:0] clamp(longint v);
      if (v > FOOT_LIMIT) v = FOOT_LIMIT;
      if (v < -FOOT_LIMIT) v = -FOOT_LIMIT;
      return v[lfk_pkg::FOOT_W-1:0];
    endfunction

    function void note_angles(logic signed [15:0] c, logic signed [15:0] f,
                              logic signed [15:0] t);
      longint sa, ca, s2, c2, s3, c3, reach32, reach16, z32;
      foot_pos_t e;
      sincos(longint'(c) - 9000, sa, ca);
      sincos(longint'(f), s2, c2);
      sincos(longint'(t), s3, c3);
      reach32 = (coxa_len <<< 32) + femur_len * s2 * 65536
              + tibia_len * (s3 * s2 + c3 * c2);
      reach16 = (reach32 + (64'sd1 <<< 15)) >>> 16;
      z32 = -(femur_len * c2 * 65536) + tibia_len * (s2 * c3 - c2 * s3);
      e.x = clamp((reach16 * ca + (64'sd1 <<< 31)) >>> 32);
      e.y = clamp((reach16 * sa + (64'sd1 <<< 31)) >>> 32);
      e.z = clamp((z32 + (64'sd1 <<< 31)) >>> 32);
      foot_q.push_back(e);
    endfunction

    function void check_foot(logic signed [lfk_pkg::FOOT_W-1:0] x,
                             logic signed [lfk_pkg::FOOT_W-1:0] y,
                             logic signed [lfk_pkg::FOOT_W-1:0] z);
      foot_pos_t e;
      if (foot_q.size() == 0) begin
        $error("unexpected foot transaction x=%0d y=%0d z=%0d", x, y, z);
        errors++;
        return;
      end
      e = foot_q.pop_front();
      if (x !== e.x) begin
        $error("foot_x expected %0d actual %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("foot_y expected %0d actual %0d", e.y, y);
        errors++;
      end
      if (z !== e.z) begin
        $error("foot_z expected %0d actual %0d", e.z, z);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [lfk_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lfk_pkg::LEN_W-1:0] cfg_data;
  int send_idle_pct;
  int recv_stall_pct;
  int unsigned cycles;
  foot_scoreboard sb;

  lfk_in_if  angle_ch ();
  lfk_out_if foot_ch ();

  leg_forward_kinematics u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (angle_ch),
    .out_o      (foot_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycles = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    angle_ch.valid = 1'b0;
    angle_ch.coxa_angle = '0;
    angle_ch.femur_angle = '0;
    angle_ch.tibia_angle = '0;
    foot_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[leg_forward_kinematics] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    foot_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && angle_ch.valid && angle_ch.ready) begin
      sb.note_angles(angle_ch.coxa_angle, angle_ch.femur_angle, angle_ch.tibia_angle);
    end
    if (rst_ni && foot_ch.valid && foot_ch.ready) begin
      sb.check_foot(foot_ch.foot_x, foot_ch.foot_y, foot_ch.foot_z);
    end
  end

  task automatic send_angles(logic signed [15:0] c, logic signed [15:0] f,
                             logic signed [15:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.coxa_angle <= c;
    angle_ch.femur_angle <= f;
    angle_ch.tibia_angle <= t;
    do @(posedge clk_i); while (!angle_ch.ready);
  endtask

  task automatic drain();
    angle_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.foot_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(logic [lfk_pkg::CFG_IDX_W-1:0] idx,
                              logic [lfk_pkg::LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_length(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(9) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(36000)) - 18000);
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      send_angles(rand_angle(), rand_angle(), rand_angle());
      if (i == n / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    logic signed [15:0] corner[11];
    corner = '{0, 18000, -18000, 9000, -9000, 4500, 27000, -27000,
               32767, -32768, 36000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 11; i++) begin
      send_angles(corner[i], corner[(i + 3) % 11], corner[(i + 7) % 11]);
    end
    send_angles(0, 9000, -9000);
    send_angles(9000, 0, 0);
    drain();

    write_length(lfk_pkg::CFG_COXA, 14'd16383);
    write_length(lfk_pkg::CFG_FEMUR, 14'd16383);
    write_length(lfk_pkg::CFG_TIBIA, 14'd16383);
    write_length(2'd3, 14'd77);
    for (int i = 0; i < 11; i++) begin
      send_angles(corner[i], corner[(i + 5) % 11], corner[i]);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      random_burst(60);
      drain();
      write_length(lfk_pkg::CFG_COXA, phase == 0 ? 14'd0 : 14'($urandom()));
      write_length(lfk_pkg::CFG_FEMUR, phase == 1 ? 14'd0 : 14'($urandom()));
      write_length(lfk_pkg::CFG_TIBIA, phase == 2 ? 14'd0 : 14'($urandom()));
      random_burst(60);
      drain();
      write_length(lfk_pkg::CFG_COXA, 14'($urandom()));
      write_length(lfk_pkg::CFG_FEMUR, 14'($urandom()));
      write_length(lfk_pkg::CFG_TIBIA, 14'($urandom()));
      random_burst(50);
      drain();
    end

    if (sb.errors == 0) begin
      $display("[leg_forward_kinematics] OK");
    end else begin
      $display("[leg_forward_kinematics] ERROR");
    end
    $finish;
  end

endmodule
